// ===== design/bdgd_pkg.sv =====
`default_nettype none

package bdgd_pkg;

   // Geometry of the event history and of the time stamps.
   localparam int HISTORY_DEPTH = 4;
   localparam int TIME_BITS     = 32;
   localparam int CFG_BITS      = 16;

   // The pin is active low: this level means pressed.
   localparam logic PIN_LOW = 1'b0;

   // Stream payload widths, rounded up to whole bytes.
   localparam int REQ_BITS       = 1 + TIME_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS       = 2 + TIME_BITS + 1 + 1;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_DELAY    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_THRESHOLD    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_THRESHOLD = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [CFG_BITS-1:0] DEBOUNCE_DELAY_RESET    = 16'd50;
   localparam logic [CFG_BITS-1:0] HOLD_THRESHOLD_RESET    = 16'd500;
   localparam logic [CFG_BITS-1:0] RELEASE_THRESHOLD_RESET = 16'd1000;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [CFG_BITS-1:0]  cfg_type;

   typedef enum logic [1:0] {
      GESTURE_IDLE   = 2'd0,
      GESTURE_SINGLE = 2'd1,
      GESTURE_DOUBLE = 2'd2,
      GESTURE_HELD   = 2'd3
   } gesture_type;

   // One poll after decoding: pressed flag and time.
   typedef struct packed {
      logic     reading;
      time_type now;
   } poll_type;

   // Event history, entry 0 is the newest.
   typedef struct packed {
      logic [HISTORY_DEPTH-1:0]     level;
      time_type [HISTORY_DEPTH-1:0] stamp;
   } hist_type;

   // Gesture thresholds handed to the classifier.
   typedef struct packed {
      cfg_type hold_threshold;
      cfg_type release_threshold;
   } thresh_type;

   // One result item.
   typedef struct packed {
      logic        pressed;
      logic        changed;
      time_type    stamp;
      gesture_type gesture;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/button_debounce_gesture_detector.sv =====
`default_nettype none

// Button debounce and gesture detector. Each request is one poll of an
// active-low button pin with a millisecond time stamp; each poll yields
// exactly one response with the current gesture (idle, single press, double
// press or held), the time of the event that set it, a flag for a gesture
// set by this poll and the debounced level. Polls are taken one per clock
// cycle, sustained while the response side is not stalled; a poll passes
// through the request register, then through the debounce, history and
// classification logic into the response register. Each poll reads the
// state that the previous poll left there. The three thresholds are to be
// written through the csr port only while no polls are in flight; the block
// itself does not enforce this. csr_ready is always high and writes to an
// unused index are dropped.
module button_debounce_gesture_detector (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Request stream.
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // Fields from bit 0: raw_level, now_ms.
   input  wire logic [bdgd_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // Response stream.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // Fields from bit 0: gesture, gesture_time, gesture_changed, pressed.
   output logic [bdgd_pkg::RSP_TDATA_BITS-1:0]         rsp_tdata,
   // Configuration writes.
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [bdgd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire bdgd_pkg::cfg_type                      csr_data
);
   import bdgd_pkg::*;

   cfg_type    debounce_delay_ff;
   cfg_type    hold_threshold_ff;
   cfg_type    release_threshold_ff;
   thresh_type thresh;

   logic       req_valid_ff;
   logic       req_valid_in;
   poll_type   poll_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    result;
   logic       advance;
   logic       stable_next;
   hist_type   hist_next;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_delay_ff    <= DEBOUNCE_DELAY_RESET;
         hold_threshold_ff    <= HOLD_THRESHOLD_RESET;
         release_threshold_ff <= RELEASE_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE_DELAY:    debounce_delay_ff    <= csr_data;
            CSR_HOLD_THRESHOLD:    hold_threshold_ff    <= csr_data;
            CSR_RELEASE_THRESHOLD: release_threshold_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign thresh.hold_threshold    = hold_threshold_ff;
   assign thresh.release_threshold = release_threshold_ff;

   // Pipeline control: a poll is evaluated when the response slot is free.
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !req_valid_ff || advance;
   assign req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         poll_ff.reading <= (req_tdata[0] == PIN_LOW);
         poll_ff.now     <= req_tdata[TIME_BITS:1];
      end
   end

   bdgd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .poll           (poll_ff),
      .debounce_delay (debounce_delay_ff),
      .stable_next    (stable_next)
   );

   bdgd_history u_history (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stable_next (stable_next),
      .now         (poll_ff.now),
      .hist_next   (hist_next)
   );

   bdgd_classify u_classify (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .hist    (hist_next),
      .now     (poll_ff.now),
      .thresh  (thresh),
      .result  (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RSP_BITS){1'b0}},
                        rsp_ff.pressed, rsp_ff.changed, rsp_ff.stamp, rsp_ff.gesture};

endmodule

`default_nettype wire

// ===== design/bdgd_debounce.sv =====
`default_nettype none

module bdgd_debounce (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire bdgd_pkg::poll_type poll,
   input  wire bdgd_pkg::cfg_type debounce_delay,
   output logic                   stable_next
);
   import bdgd_pkg::*;

   logic     unstable_ff;
   logic     unstable_in;
   logic     stable_ff;
   logic     stable_in;
   time_type last_change_ff;
   time_type last_change_in;
   time_type settle_age;

   // Restart the settle timer whenever the raw level moves.
   assign unstable_in    = poll.reading;
   assign last_change_in = (poll.reading != unstable_ff) ? poll.now : last_change_ff;

   // The level is taken once it has stayed put for longer than the delay.
   assign settle_age  = poll.now - last_change_in;
   assign stable_in   = (settle_age > TIME_BITS'(debounce_delay)) ? poll.reading : stable_ff;
   assign stable_next = stable_in;

   // Debounce state, updated once per evaluated poll.
   always_ff @(posedge clock) begin
      if (reset) begin
         unstable_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         last_change_ff <= '0;
      end else if (advance) begin
         unstable_ff    <= unstable_in;
         stable_ff      <= stable_in;
         last_change_ff <= last_change_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bdgd_history.sv =====
`default_nettype none

module bdgd_history (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               stable_next,
   input  wire bdgd_pkg::time_type now,
   output bdgd_pkg::hist_type      hist_next
);
   import bdgd_pkg::*;

   hist_type hist_ff;
   hist_type hist_in;
   logic     push;

   // A change of the stable level shifts the history by one entry.
   assign push = (stable_next != hist_ff.level[0]);

   always_comb begin
      hist_in = hist_ff;
      if (push) begin
         for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
            hist_in.level[k] = hist_ff.level[k-1];
            hist_in.stamp[k] = hist_ff.stamp[k-1];
         end
         hist_in.level[0] = stable_next;
         hist_in.stamp[0] = now;
      end
   end

   assign hist_next = hist_in;

   // History registers; reset leaves every entry released at time zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (advance) begin
         hist_ff <= hist_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bdgd_classify.sv =====
`default_nettype none

module bdgd_classify (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire bdgd_pkg::hist_type   hist,
   input  wire bdgd_pkg::time_type   now,
   input  wire bdgd_pkg::thresh_type thresh,
   output bdgd_pkg::rsp_type         result
);
   import bdgd_pkg::*;

   gesture_type gesture_ff;
   gesture_type gesture_in;
   time_type    stamp_ff;
   time_type    stamp_in;
   time_type    t0;
   time_type    age;
   time_type    hold_ext;
   time_type    release_ext;
   logic        short_01;
   logic        short_23;
   logic        two_presses;
   logic        try_en;
   gesture_type try_gesture;
   logic        accept;

   assign t0          = hist.stamp[0];
   assign age         = now - t0;
   assign hold_ext    = TIME_BITS'(thresh.hold_threshold);
   assign release_ext = TIME_BITS'(thresh.release_threshold);

   // A short press is a release that follows its press within the hold time.
   assign short_01 = !hist.level[0] && hist.level[1] &&
                     ((hist.stamp[0] - hist.stamp[1]) < hold_ext);
   assign short_23 = !hist.level[2] && hist.level[3] &&
                     ((hist.stamp[2] - hist.stamp[3]) < hold_ext);
   assign two_presses = short_01 && short_23 &&
                        ((hist.stamp[0] - hist.stamp[3]) < hold_ext);

   // Pick the candidate gesture; the first matching rule ends the search.
   always_comb begin
      try_en      = 1'b0;
      try_gesture = GESTURE_IDLE;
      if (hist.level[0]) begin
         if (age > hold_ext) begin
            try_en      = 1'b1;
            try_gesture = GESTURE_HELD;
         end
      end else if ((age > release_ext) && (gesture_ff == GESTURE_HELD)) begin
         try_en      = 1'b1;
         try_gesture = GESTURE_IDLE;
      end else if (two_presses) begin
         try_en      = 1'b1;
         try_gesture = GESTURE_DOUBLE;
      end else if (short_01 && !(age < hold_ext)) begin
         try_en      = 1'b1;
         try_gesture = GESTURE_SINGLE;
      end
   end

   // A candidate carrying the current gesture's time stamp is dropped.
   assign accept     = try_en && (t0 != stamp_ff);
   assign gesture_in = accept ? try_gesture : gesture_ff;
   assign stamp_in   = accept ? t0 : stamp_ff;

   assign result.gesture = gesture_in;
   assign result.stamp   = stamp_in;
   assign result.changed = accept;
   assign result.pressed = hist.level[0];

   // Current gesture and the time of the event that set it.
   always_ff @(posedge clock) begin
      if (reset) begin
         gesture_ff <= GESTURE_IDLE;
         stamp_ff   <= '0;
      end else if (advance) begin
         gesture_ff <= gesture_in;
         stamp_ff   <= stamp_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bdgd_checker.sv =====
`default_nettype none

module bdgd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [bdgd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import bdgd_pkg::*;

   localparam int STAMP_LO   = 2;
   localparam int CHANGED_AT = 2 + TIME_BITS;

   logic     rsp_take;
   logic     changed;
   time_type stamp;
   logic [1:0] gesture_code;
   time_type last_stamp_ff;
   logic [1:0] last_gesture_ff;

   assign rsp_take     = rsp_tvalid && rsp_tready;
   assign changed      = rsp_tdata[CHANGED_AT];
   assign stamp        = rsp_tdata[STAMP_LO +: TIME_BITS];
   assign gesture_code = rsp_tdata[1:0];

   // Gesture and stamp of the last response taken, starting from idle at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff   <= '0;
         last_gesture_ff <= GESTURE_IDLE;
      end else if (rsp_take) begin
         last_stamp_ff   <= stamp;
         last_gesture_ff <= gesture_code;
      end
   end

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A request followed by a free response side reaches the response register.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("request did not reach the response register");

   // A new gesture always carries a new time stamp.
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && changed |-> stamp != last_stamp_ff)
      else $error("gesture change with a repeated time stamp");

   // Without a change, gesture and stamp stay as last reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && !changed |-> stamp == last_stamp_ff && gesture_code == last_gesture_ff)
      else $error("gesture moved without a change flag");

endmodule

bind button_debounce_gesture_detector bdgd_checker u_bdgd_checker (.*);

`default_nettype wire
